FILE: hdl/amgs_pkg.sv
// Package for the adjacency matrix graph store: sizes, action and status codes,
// request and result payload types, and the weight saturation function.
// No dependencies.
`default_nettype none

package amgs_pkg;

  localparam int MAX_VERTS   = 64;
  localparam int WEIGHT_BITS = 16;
  localparam int VERT_W      = $clog2(MAX_VERTS);
  localparam int CNT_W       = $clog2(MAX_VERTS + 1);
  localparam int CELL_W      = 2 * VERT_W;
  localparam int GRP_SIZE    = 8;
  localparam int GRP_COUNT   = MAX_VERTS / GRP_SIZE;
  localparam int GRP_W       = $clog2(GRP_COUNT);
  localparam int GRP_LSB_W   = $clog2(GRP_SIZE);

  localparam logic [2:0] ACT_CLEAR  = 3'd0;
  localparam logic [2:0] ACT_INSERT = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_READ   = 3'd3;
  localparam logic [2:0] ACT_FIRST  = 3'd4;
  localparam logic [2:0] ACT_NEXT   = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_NOEDGE = 2'd2;

  localparam logic signed [15:0] NO_EDGE_WEIGHT = -16'sd256;

  localparam logic [0:0]      REG_VERTEX_COUNT   = 1'b0;
  localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = CNT_W'(64);

  localparam longint WEIGHT_HI = (64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1;
  localparam longint WEIGHT_LO = -WEIGHT_HI - 64'sd1;

  typedef struct packed {
    logic [2:0]         action;
    logic [5:0]         vertex_a;
    logic [5:0]         vertex_b;
    logic               cursor_none;
    logic signed [15:0] weight_in;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] weight_out;
    logic [5:0]         neighbour;
    logic               found;
  } rsp_t;

  function automatic logic signed [WEIGHT_BITS-1:0] sat_weight(
    input logic signed [15:0] w
  );
    logic signed [32:0] wx;
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    wx = 33'(w);
    hi = 33'(WEIGHT_HI);
    lo = 33'(WEIGHT_LO);
    if (wx > hi) begin
      return hi[WEIGHT_BITS-1:0];
    end else if (wx < lo) begin
      return lo[WEIGHT_BITS-1:0];
    end
    return wx[WEIGHT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/adjacency_matrix_graph_store_core.sv
// Undirected weighted adjacency matrix store: row-valid memory, weight memory,
// a small sequencer with an 8-bit group scanner, and an APB register port.
// Depends on amgs_pkg.
// Sequence per request: clear, read, unused actions, range errors, a missing edge and a
// cursor of none go from S_EVAL_A to S_DONE; insert and a remove of an edge add S_EVAL_B;
// a neighbour scan adds S_SCAN, one 8-vertex group per cycle through the group encoder.
// One request at a time; a waiting result holds the next.
// Reset: synchronous; empties the store through per-row valid flops, sets
// vertex_count to 64. Weight memory is not cleared.
`default_nettype none

module adjacency_matrix_graph_store_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output      logic          req_stall,
  input  wire amgs_pkg::req_t req,
  output      logic          rsp_valid,
  input  wire logic          rsp_stall,
  output      amgs_pkg::rsp_t rsp,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output      logic [31:0]   prdata,
  output      logic          pready
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EVAL_A = 5'b00010,
    S_EVAL_B = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t                                     state;
  amgs_pkg::req_t                             cur;
  amgs_pkg::rsp_t                             res;
  logic [amgs_pkg::CNT_W-1:0]                 vertex_count;
  logic [amgs_pkg::MAX_VERTS-1:0]             row_valid;
  logic [amgs_pkg::MAX_VERTS-1:0]             row;
  logic [amgs_pkg::GRP_W-1:0]                 grp;

  logic [amgs_pkg::MAX_VERTS-1:0]             vmem [amgs_pkg::MAX_VERTS];
  logic signed [amgs_pkg::WEIGHT_BITS-1:0]    wmem [amgs_pkg::MAX_VERTS * amgs_pkg::MAX_VERTS];
  logic [amgs_pkg::MAX_VERTS-1:0]             vq;
  logic                                       vq_ok;
  logic signed [amgs_pkg::WEIGHT_BITS-1:0]    wq;

  logic [amgs_pkg::VERT_W-1:0]                rd_row;
  logic                                       vm_we;
  logic [amgs_pkg::VERT_W-1:0]                vm_waddr;
  logic [amgs_pkg::MAX_VERTS-1:0]             vm_wdata;
  logic                                       wm_we;
  logic [amgs_pkg::CELL_W-1:0]                wm_waddr;
  logic signed [amgs_pkg::WEIGHT_BITS-1:0]    wm_wdata;

  logic [amgs_pkg::CNT_W-1:0]                 n;
  logic [amgs_pkg::MAX_VERTS-1:0]             row_a;
  logic [amgs_pkg::MAX_VERTS-1:0]             row_a_new;
  logic [amgs_pkg::MAX_VERTS-1:0]             row_b;
  logic [amgs_pkg::MAX_VERTS-1:0]             row_b_new;
  logic [amgs_pkg::MAX_VERTS-1:0]             scan_mask;
  logic [amgs_pkg::CNT_W-1:0]                 start;
  logic                                       a_bad;
  logic                                       b_bad;
  logic                                       edge_ab;
  logic                                       del;
  logic                                       set_bit;
  logic [amgs_pkg::GRP_SIZE-1:0]              chunk;
  logic [amgs_pkg::GRP_LSB_W-1:0]             enc;
  logic                                       cfg_wr;

  assign req_stall = (state != S_IDLE);
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && (paddr[2] == amgs_pkg::REG_VERTEX_COUNT);
  assign prdata    = (paddr[2] == amgs_pkg::REG_VERTEX_COUNT) ? 32'(vertex_count) : 32'd0;

  always_comb begin
    n = (vertex_count > amgs_pkg::CNT_W'(amgs_pkg::MAX_VERTS))
        ? amgs_pkg::CNT_W'(amgs_pkg::MAX_VERTS) : vertex_count;
    row_a     = vq_ok ? vq : '0;
    a_bad     = ({1'b0, cur.vertex_a} >= n);
    b_bad     = ({1'b0, cur.vertex_b} >= n);
    edge_ab   = row_a[cur.vertex_b];
    del       = (cur.weight_in == amgs_pkg::NO_EDGE_WEIGHT);
    set_bit   = (cur.action == amgs_pkg::ACT_INSERT) && !del;
    row_a_new = row_a;
    row_a_new[cur.vertex_b] = set_bit;
    row_b     = (cur.vertex_a == cur.vertex_b) ? row : (vq_ok ? vq : '0);
    row_b_new = row_b;
    row_b_new[cur.vertex_a] = set_bit;
    start     = (cur.action == amgs_pkg::ACT_NEXT) ? ({1'b0, cur.vertex_b} + 1'b1) : '0;
    for (int i = 0; i < amgs_pkg::MAX_VERTS; i++) begin
      scan_mask[i] = (amgs_pkg::CNT_W'(i) >= start) && (amgs_pkg::CNT_W'(i) < n);
    end
    chunk = row[{grp, {amgs_pkg::GRP_LSB_W{1'b0}}} +: amgs_pkg::GRP_SIZE];
    enc   = '0;
    for (int i = amgs_pkg::GRP_SIZE - 1; i >= 0; i--) begin
      if (chunk[i]) begin
        enc = amgs_pkg::GRP_LSB_W'(i);
      end
    end
  end

  always_comb begin
    rd_row   = (state == S_IDLE) ? req.vertex_a : cur.vertex_b;
    vm_we    = 1'b0;
    vm_waddr = cur.vertex_a;
    vm_wdata = row_a_new;
    wm_we    = 1'b0;
    wm_waddr = {cur.vertex_a, cur.vertex_b};
    wm_wdata = amgs_pkg::sat_weight(cur.weight_in);
    unique case (state)
      S_EVAL_A: begin
        if (!a_bad && !b_bad) begin
          if (cur.action == amgs_pkg::ACT_INSERT) begin
            vm_we = 1'b1;
            wm_we = !del;
          end else if (cur.action == amgs_pkg::ACT_REMOVE && edge_ab) begin
            vm_we = 1'b1;
          end
        end
      end
      S_EVAL_B: begin
        vm_we    = 1'b1;
        vm_waddr = cur.vertex_b;
        vm_wdata = row_b_new;
        wm_we    = set_bit;
        wm_waddr = {cur.vertex_b, cur.vertex_a};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmem[vm_waddr] <= vm_wdata;
    end
    vq <= vmem[rd_row];
  end

  always_ff @(posedge clk) begin
    if (wm_we) begin
      wmem[wm_waddr] <= wm_wdata;
    end
    wq <= wmem[{req.vertex_a, req.vertex_b}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      row_valid    <= '0;
      rsp_valid    <= 1'b0;
      vertex_count <= amgs_pkg::VERTEX_COUNT_RESET;
    end else begin
      if (cfg_wr) begin
        vertex_count <= pwdata[amgs_pkg::CNT_W-1:0];
      end
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      vq_ok <= row_valid[rd_row];
      if (vm_we) begin
        row_valid[vm_waddr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur            <= req;
            res.status     <= amgs_pkg::ST_OK;
            res.weight_out <= amgs_pkg::NO_EDGE_WEIGHT;
            res.neighbour  <= '0;
            res.found      <= 1'b0;
            state          <= S_EVAL_A;
          end
        end
        S_EVAL_A: begin
          case (cur.action) inside
            amgs_pkg::ACT_CLEAR: begin
              row_valid <= '0;
              state     <= S_DONE;
            end
            amgs_pkg::ACT_INSERT, amgs_pkg::ACT_REMOVE, amgs_pkg::ACT_READ: begin
              if (a_bad || b_bad) begin
                res.status <= amgs_pkg::ST_RANGE;
                state      <= S_DONE;
              end else if (cur.action == amgs_pkg::ACT_INSERT) begin
                row   <= row_a_new;
                state <= S_EVAL_B;
              end else if (!edge_ab) begin
                res.status <= amgs_pkg::ST_NOEDGE;
                state      <= S_DONE;
              end else begin
                res.weight_out <= 16'(wq);
                row            <= row_a_new;
                state          <= (cur.action == amgs_pkg::ACT_REMOVE) ? S_EVAL_B : S_DONE;
              end
            end
            amgs_pkg::ACT_FIRST, amgs_pkg::ACT_NEXT: begin
              if (a_bad) begin
                res.status <= amgs_pkg::ST_RANGE;
                state      <= S_DONE;
              end else if (!(cur.action == amgs_pkg::ACT_NEXT && cur.cursor_none)) begin
                row   <= row_a & scan_mask;
                grp   <= '0;
                state <= S_SCAN;
              end else begin
                state <= S_DONE;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_EVAL_B: begin
          state <= S_DONE;
        end
        S_SCAN: begin
          if (chunk != '0) begin
            res.found     <= 1'b1;
            res.neighbour <= 6'({grp, enc});
            state         <= S_DONE;
          end else if (grp == amgs_pkg::GRP_W'(amgs_pkg::GRP_COUNT - 1)) begin
            state <= S_DONE;
          end else begin
            grp <= grp + 1'b1;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL_A && cur.action == amgs_pkg::ACT_CLEAR) |=> (row_valid == '0))
    else $error("clear left rows valid");

  a_second_write_only_for_update: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL_B) |->
      (cur.action == amgs_pkg::ACT_INSERT || cur.action == amgs_pkg::ACT_REMOVE))
    else $error("symmetric write for non-update action");

  a_transfer_starts_eval: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_EVAL_A))
    else $error("request transfer did not start evaluation");

  a_found_is_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.found) |-> (rsp.status == amgs_pkg::ST_OK))
    else $error("neighbour found with error status");

endmodule

`default_nettype wire
